FILE: src/cip_pkg.sv
// Shared constants and codes for the chroma intra predictor.
// No dependencies.
`default_nettype none
package cip_pkg;

    localparam int MaxBlockSizeDef = 16;
    localparam int SampleBitsDef   = 14;

    typedef enum logic [1:0] {
        MODE_TOP     = 2'd0,
        MODE_LEFT    = 2'd1,
        MODE_CORNER  = 2'd2,
        MODE_PREDICT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PRED_DC    = 2'd0,
        PRED_HOR   = 2'd1,
        PRED_VER   = 2'd2,
        PRED_PLANE = 2'd3
    } t_pred;

    typedef enum logic {
        REG_BIT_DEPTH     = 1'b0,
        REG_CHROMA_FORMAT = 1'b1
    } t_reg;

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_420  = 2'd1;
    localparam logic [1:0] FMT_444  = 2'd3;

    localparam logic [3:0] BIT_DEPTH_MIN = 4'd8;

endpackage
`default_nettype wire

FILE: src/cip_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none
module cip_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                i_wdata,
    input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/chroma_intra_predictor.sv
// Chroma intra predictor top level: neighbour RAMs, sweep, plane setup, output.
// Depends on cip_pkg and cip_ram.
`default_nettype none
// Load words (top, left, corner) are written straight into the neighbour RAMs
// or the corner register. A predict word first sweeps both neighbour RAMs (16
// reads, one per cycle), summing for DC, then does the plane setup in S_PARAM
// and S_BASE, then builds each result word by four RAM reads, one column per
// cycle, and shows it until the downstream takes it; the input is stalled
// throughout. An unavailable-neighbour error word comes out the cycle after.
module chroma_intra_predictor #(
    parameter int MAX_BLOCK_SIZE = cip_pkg::MaxBlockSizeDef,
    parameter int SAMPLE_BITS    = cip_pkg::SampleBitsDef
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [1:0]             i_mode,
    input  wire  [3:0]             i_index,
    input  wire  [SAMPLE_BITS-1:0] i_cb_sample,
    input  wire  [SAMPLE_BITS-1:0] i_cr_sample,
    input  wire  [1:0]             i_pred_mode,
    input  wire                    i_left_top_avail,
    input  wire                    i_left_bottom_avail,
    input  wire                    i_up_avail,
    input  wire                    i_corner_avail,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [3:0]             o_row,
    output logic [1:0]             o_col_group,
    output logic [SAMPLE_BITS-1:0] o_cb0,
    output logic [SAMPLE_BITS-1:0] o_cb1,
    output logic [SAMPLE_BITS-1:0] o_cb2,
    output logic [SAMPLE_BITS-1:0] o_cb3,
    output logic [SAMPLE_BITS-1:0] o_cr0,
    output logic [SAMPLE_BITS-1:0] o_cr1,
    output logic [SAMPLE_BITS-1:0] o_cr2,
    output logic [SAMPLE_BITS-1:0] o_cr3,
    output logic                   o_last,
    output logic                   o_status,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [0:0]             i_cfg_index,
    input  wire  [3:0]             i_cfg_data
);
    import cip_pkg::*;

    localparam int AW   = $clog2(MAX_BLOCK_SIZE > 1 ? MAX_BLOCK_SIZE : 2);
    localparam int SB   = SAMPLE_BITS;
    localparam int EW   = 2 * SB;
    localparam int SUMW = SB + 2;
    localparam int ACCW = SB + 8;
    localparam int PW   = SB + 10;
    localparam int VW   = SB + 14;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SWEEP  = 6'b000010,
        S_PARAM  = 6'b000100,
        S_BASE   = 6'b001000,
        S_GATHER = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [3:0]  r_bit_depth;
    logic [1:0]  r_chroma_format;
    logic        r_dv;
    logic [EW-1:0] r_corner;
    t_pred       r_pm;
    logic        r_lt, r_lb, r_up;
    logic [4:0]  r_cnt;
    logic [2:0]  r_k;
    logic [3:0]  r_didx;
    logic        r_tin, r_lin;
    logic [SUMW-1:0] r_st [2][4];
    logic [SUMW-1:0] r_sl [2][4];
    logic signed [ACCW-1:0] r_hs [2];
    logic signed [ACCW-1:0] r_vs [2];
    logic [SB-1:0] r_topl [2];
    logic [SB-1:0] r_leftl [2];
    logic signed [PW-1:0] r_pb [2];
    logic signed [PW-1:0] r_pc [2];
    logic signed [VW-1:0] r_base [2];
    logic [3:0]  r_row;
    logic [1:0]  r_grp;
    logic [SB-1:0] r_cb [4];
    logic [SB-1:0] r_cr [4];
    logic        r_last, r_status;

    logic        in_fire, out_fire;
    logic        w16, h16;
    logic [3:0]  bd;
    logic [SB-1:0] mx, dflt;
    logic signed [5:0] xcf_off, ycf_off, corner_x, corner_y;
    logic signed [4:0] yoff;
    logic signed [6:0] kb, kc;
    logic        avail_ok, idx_ok;
    logic [3:0]  ra_top, ra_left;
    logic [EW-1:0] top_q, left_q;
    logic [SB-1:0] topv [2];
    logic [SB-1:0] leftv [2];
    logic signed [5:0] coef_x, coef_y, xoff;
    logic signed [ACCW-1:0] prod_h [2];
    logic signed [ACCW-1:0] prod_v [2];
    logic signed [31:0] tb [2];
    logic signed [31:0] tc [2];
    logic [SB:0] s_lt [2];
    logic signed [VW-1:0] tbase [2];
    logic signed [VW-1:0] pv [2];
    logic signed [VW-1:0] psh [2];
    logic [SB-1:0] samp [2];
    logic [SUMW-1:0] dsl, dst;
    logic [SUMW:0] dboth;
    logic        dleft, last_now;

    assign in_fire     = i_valid && !o_stall;
    assign out_fire    = o_valid && !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_EMIT);
    assign o_cfg_ready = 1'b1;

    assign w16 = (r_chroma_format == FMT_444);
    assign h16 = !((r_chroma_format == FMT_420) || (r_chroma_format == FMT_NONE));
    assign bd  = (r_bit_depth < BIT_DEPTH_MIN) ? BIT_DEPTH_MIN :
                 (r_bit_depth > 4'(SB)) ? 4'(SB) : r_bit_depth;
    assign mx   = SB'((32'd1 << bd) - 32'd1);
    assign dflt = SB'(32'd1 << (bd - 4'd1));
    assign xcf_off  = w16 ? 6'sd7 : 6'sd3;
    assign ycf_off  = h16 ? 6'sd7 : 6'sd3;
    assign corner_x = w16 ? -6'sd8 : -6'sd4;
    assign corner_y = h16 ? -6'sd8 : -6'sd4;
    assign yoff     = h16 ? 5'sd7 : 5'sd3;
    assign kb       = w16 ? 7'sd5 : 7'sd34;
    assign kc       = h16 ? 7'sd5 : 7'sd34;
    assign idx_ok   = ({1'b0, i_index} < 5'(MAX_BLOCK_SIZE));

    always_comb begin
        case (t_pred'(i_pred_mode))
            PRED_HOR:   avail_ok = i_left_top_avail && i_left_bottom_avail;
            PRED_VER:   avail_ok = i_up_avail;
            PRED_PLANE: avail_ok = i_left_top_avail && i_left_bottom_avail &&
                                   i_up_avail && i_corner_avail;
            default:    avail_ok = 1'b1;
        endcase
    end

    always_comb begin
        case (r_state)
            S_SWEEP: begin
                ra_top  = r_cnt[3:0];
                ra_left = r_cnt[3:0];
            end
            S_GATHER: begin
                ra_top  = {r_grp, r_k[1:0]};
                ra_left = r_row;
            end
            default: begin
                ra_top  = 4'd0;
                ra_left = 4'd0;
            end
        endcase
    end

    cip_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCK_SIZE)) u_top_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && (t_mode'(i_mode) == MODE_TOP) && idx_ok),
        .i_waddr (i_index[AW-1:0]),
        .i_wdata ({i_cr_sample, i_cb_sample}),
        .i_raddr (ra_top[AW-1:0]),
        .o_rdata (top_q)
    );

    cip_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCK_SIZE)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && (t_mode'(i_mode) == MODE_LEFT) && idx_ok),
        .i_waddr (i_index[AW-1:0]),
        .i_wdata ({i_cr_sample, i_cb_sample}),
        .i_raddr (ra_left[AW-1:0]),
        .o_rdata (left_q)
    );

    // sweep coefficients and per-column sample math
    always_comb begin
        coef_x = $signed({2'b00, r_didx}) - xcf_off;
        coef_y = $signed({2'b00, r_didx}) - ycf_off;
        xoff   = $signed({2'b00, r_grp, r_didx[1:0]}) - xcf_off;
        dleft  = h16 ? (r_row[3] ? r_lb : r_lt) : ((r_row[3:2] == 2'd0) ? r_lt : r_lb);
        dsl    = '0;
        dst    = '0;
        dboth  = '0;
        last_now = (r_row == (h16 ? 4'd15 : 4'd7)) && (r_grp == (w16 ? 2'd3 : 2'd1));
        for (int c = 0; c < 2; c++) begin
            topv[c]  = r_tin ? top_q[c*SB +: SB] : '0;
            leftv[c] = r_lin ? left_q[c*SB +: SB] : '0;
            prod_h[c] = ACCW'(coef_x) * ACCW'($signed({1'b0, topv[c]}));
            prod_v[c] = ACCW'(coef_y) * ACCW'($signed({1'b0, leftv[c]}));
            tb[c] = 32'(r_hs[c]) * 32'(kb) + 32'sd32;
            tc[c] = 32'(r_vs[c]) * 32'(kc) + 32'sd32;
            s_lt[c] = {1'b0, r_leftl[c]} + {1'b0, r_topl[c]};
            tbase[c] = $signed(VW'({s_lt[c], 4'b0000})) + VW'(16)
                       - VW'(r_pc[c]) * VW'(yoff);
            pv[c]  = r_base[c] + VW'(r_pb[c]) * VW'(xoff);
            psh[c] = pv[c] >>> 5;
            dsl    = r_sl[c][r_row[3:2]];
            dst    = r_st[c][r_grp];
            dboth  = {1'b0, dsl} + {1'b0, dst} + (SUMW+1)'(4);
            case (r_pm)
                PRED_HOR: samp[c] = leftv[c];
                PRED_VER: samp[c] = topv[c];
                PRED_PLANE: begin
                    if (psh[c] < 0) begin
                        samp[c] = '0;
                    end else if (psh[c] > $signed(VW'(mx))) begin
                        samp[c] = mx;
                    end else begin
                        samp[c] = psh[c][SB-1:0];
                    end
                end
                default: begin
                    samp[c] = dflt;
                    if ((r_grp == 2'd0) == (r_row[3:2] == 2'd0)) begin
                        if (dleft && r_up) begin
                            samp[c] = SB'(dboth >> 3);
                        end else if (dleft) begin
                            samp[c] = SB'((dsl + SUMW'(2)) >> 2);
                        end else if (r_up) begin
                            samp[c] = SB'((dst + SUMW'(2)) >> 2);
                        end
                    end else if (r_grp != 2'd0) begin
                        if (r_up) begin
                            samp[c] = SB'((dst + SUMW'(2)) >> 2);
                        end else if (dleft) begin
                            samp[c] = SB'((dsl + SUMW'(2)) >> 2);
                        end
                    end else begin
                        if (dleft) begin
                            samp[c] = SB'((dsl + SUMW'(2)) >> 2);
                        end else if (r_up) begin
                            samp[c] = SB'((dst + SUMW'(2)) >> 2);
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && (t_mode'(i_mode) == MODE_PREDICT)) begin
                    n_state = avail_ok ? S_SWEEP : S_EMIT;
                end
            end
            S_SWEEP:  if (r_cnt[4]) n_state = S_PARAM;
            S_PARAM:  n_state = S_BASE;
            S_BASE:   n_state = S_GATHER;
            S_GATHER: if (r_k[2]) n_state = S_EMIT;
            S_EMIT: begin
                if (out_fire) begin
                    n_state = r_last ? S_IDLE : S_GATHER;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_bit_depth     <= 4'd8;
            r_chroma_format <= FMT_420;
            r_dv            <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= ((r_state == S_SWEEP) && !r_cnt[4]) ||
                       ((r_state == S_GATHER) && !r_k[2]);
            if (i_cfg_valid && o_cfg_ready) begin
                if (t_reg'(i_cfg_index) == REG_BIT_DEPTH) begin
                    r_bit_depth <= i_cfg_data;
                end else begin
                    r_chroma_format <= i_cfg_data[1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tin  <= ({1'b0, ra_top} < 5'(MAX_BLOCK_SIZE));
        r_lin  <= ({1'b0, ra_left} < 5'(MAX_BLOCK_SIZE));
        r_didx <= (r_state == S_SWEEP) ? r_cnt[3:0] : {2'b00, r_k[1:0]};
        case (r_state)
            S_IDLE: begin
                if (in_fire && (t_mode'(i_mode) == MODE_CORNER)) begin
                    r_corner <= {i_cr_sample, i_cb_sample};
                end
                if (in_fire && (t_mode'(i_mode) == MODE_PREDICT)) begin
                    r_pm  <= t_pred'(i_pred_mode);
                    r_lt  <= i_left_top_avail;
                    r_lb  <= i_left_bottom_avail;
                    r_up  <= i_up_avail;
                    r_cnt <= '0;
                    r_row <= '0;
                    r_grp <= '0;
                    r_status <= !avail_ok;
                    r_last   <= !avail_ok;
                    for (int c = 0; c < 2; c++) begin
                        r_hs[c] <= ACCW'(corner_x) *
                                   ACCW'($signed({1'b0, r_corner[c*SB +: SB]}));
                        r_vs[c] <= ACCW'(corner_y) *
                                   ACCW'($signed({1'b0, r_corner[c*SB +: SB]}));
                        for (int g = 0; g < 4; g++) begin
                            r_st[c][g] <= '0;
                            r_sl[c][g] <= '0;
                        end
                    end
                    for (int k = 0; k < 4; k++) begin
                        r_cb[k] <= '0;
                        r_cr[k] <= '0;
                    end
                end
            end
            S_SWEEP: begin
                r_cnt <= r_cnt + 5'd1;
                if (r_dv) begin
                    for (int c = 0; c < 2; c++) begin
                        r_st[c][r_didx[3:2]] <= r_st[c][r_didx[3:2]] + SUMW'(topv[c]);
                        r_sl[c][r_didx[3:2]] <= r_sl[c][r_didx[3:2]] + SUMW'(leftv[c]);
                        if (w16 || !r_didx[3]) begin
                            r_hs[c] <= r_hs[c] + prod_h[c];
                        end
                        if (h16 || !r_didx[3]) begin
                            r_vs[c] <= r_vs[c] + prod_v[c];
                        end
                        if (r_didx == (w16 ? 4'd15 : 4'd7)) begin
                            r_topl[c] <= topv[c];
                        end
                        if (r_didx == (h16 ? 4'd15 : 4'd7)) begin
                            r_leftl[c] <= leftv[c];
                        end
                    end
                end
            end
            S_PARAM: begin
                for (int c = 0; c < 2; c++) begin
                    r_pb[c] <= PW'(tb[c] >>> 6);
                    r_pc[c] <= PW'(tc[c] >>> 6);
                end
            end
            S_BASE: begin
                r_k <= '0;
                for (int c = 0; c < 2; c++) begin
                    r_base[c] <= tbase[c];
                end
            end
            S_GATHER: begin
                if (!r_k[2]) begin
                    r_k <= r_k + 3'd1;
                end
                if (r_dv) begin
                    r_cb[r_didx[1:0]] <= samp[0];
                    r_cr[r_didx[1:0]] <= samp[1];
                end
                r_last   <= last_now;
                r_status <= 1'b0;
            end
            S_EMIT: begin
                if (out_fire && !r_last) begin
                    r_k <= '0;
                    if (r_grp == (w16 ? 2'd3 : 2'd1)) begin
                        r_grp <= '0;
                        r_row <= r_row + 4'd1;
                        for (int c = 0; c < 2; c++) begin
                            r_base[c] <= r_base[c] + VW'(r_pc[c]);
                        end
                    end else begin
                        r_grp <= r_grp + 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_row       = r_row;
    assign o_col_group = r_grp;
    assign o_cb0       = r_cb[0];
    assign o_cb1       = r_cb[1];
    assign o_cb2       = r_cb[2];
    assign o_cb3       = r_cb[3];
    assign o_cr0       = r_cr[0];
    assign o_cr1       = r_cr[1];
    assign o_cr2       = r_cr[2];
    assign o_cr3       = r_cr[3];
    assign o_last      = r_last;
    assign o_status    = r_status;

`ifndef SYNTHESIS
    a_busy_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result word shown while input is open");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> !o_stall)
        else $error("block not idle after last word");
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_last && (o_row == 4'd0)))
        else $error("error word not single");
`endif

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Testbench for chroma_intra_predictor: loads neighbours, runs every prediction
// kind over several bit depth / chroma format settings, checks each result word.
// Depends on cip_pkg and the RTL under src.
module testbench;
    import cip_pkg::*;

    localparam int SB = 14;
    localparam int LIMIT = 5000000;

    typedef struct {
        t_mode         mode;
        logic [3:0]    index;
        logic [SB-1:0] cb;
        logic [SB-1:0] cr;
        t_pred         pred;
        logic          lt, lb, up, cn;
    } t_word;

    typedef struct {
        logic [3:0]    row;
        logic [1:0]    col_group;
        logic [SB-1:0] cb[4];
        logic [SB-1:0] cr[4];
        logic          last;
        logic          status;
    } t_res;

    class pred_scoreboard;
        int unsigned errors;
        logic [SB-1:0] top_nb[2][16];
        logic [SB-1:0] left_nb[2][16];
        logic [SB-1:0] corner_nb[2];
        logic [3:0] depth_reg = 4'd8;
        logic [1:0] fmt_reg = 2'd1;
        t_res want[$];

        function void set_reg(t_reg r, logic [3:0] d);
            if (r == REG_BIT_DEPTH) depth_reg = d;
            else fmt_reg = d[1:0];
        endfunction

        function int top_at(int c, int x);
            if (x < 0) return corner_nb[c];
            if (x >= 16) return 0;
            return top_nb[c][x];
        endfunction

        function int left_at(int c, int y);
            if (y < 0) return corner_nb[c];
            if (y >= 16) return 0;
            return left_nb[c][y];
        endfunction

        function int dc_val(int c, int x, int y, int h, bit lt, bit lb, bit up, int bd);
            int xo, yo, sl, st;
            bit lf;
            xo = x & ~3;
            yo = y & ~3;
            lf = (yo < h / 2) ? lt : lb;
            sl = 0;
            st = 0;
            for (int i = 0; i < 4; i++) begin
                sl += left_at(c, yo + i);
                st += top_at(c, xo + i);
            end
            if ((xo == 0 && yo == 0) || (xo > 0 && yo > 0)) begin
                if (lf && up) return (sl + st + 4) >> 3;
                if (lf) return (sl + 2) >> 2;
                if (up) return (st + 2) >> 2;
            end else if (xo > 0) begin
                if (up) return (st + 2) >> 2;
                if (lf) return (sl + 2) >> 2;
            end else begin
                if (lf) return (sl + 2) >> 2;
                if (up) return (st + 2) >> 2;
            end
            return 1 << (bd - 1);
        endfunction

        function void note_input(t_word w);
            int fmt, wd, ht, bd, xcf, ycf, hs, vs, mx, v;
            int pa[2], pb[2], pc[2];
            bit ok;
            t_res r;
            case (w.mode)
                MODE_TOP: begin
                    top_nb[0][w.index] = w.cb;
                    top_nb[1][w.index] = w.cr;
                    return;
                end
                MODE_LEFT: begin
                    left_nb[0][w.index] = w.cb;
                    left_nb[1][w.index] = w.cr;
                    return;
                end
                MODE_CORNER: begin
                    corner_nb[0] = w.cb;
                    corner_nb[1] = w.cr;
                    return;
                end
                default: ;
            endcase
            fmt = (fmt_reg == FMT_NONE) ? 1 : fmt_reg;
            wd = (fmt == FMT_444) ? 16 : 8;
            ht = (fmt == FMT_420) ? 8 : 16;
            bd = depth_reg;
            if (bd < 8) bd = 8;
            if (bd > SB) bd = SB;
            case (w.pred)
                PRED_HOR: ok = w.lt && w.lb;
                PRED_VER: ok = w.up;
                PRED_PLANE: ok = w.lt && w.lb && w.up && w.cn;
                default: ok = 1;
            endcase
            if (!ok) begin
                r.row = 0;
                r.col_group = 0;
                for (int k = 0; k < 4; k++) begin
                    r.cb[k] = 0;
                    r.cr[k] = 0;
                end
                r.last = 1;
                r.status = 1;
                want.push_back(r);
                return;
            end
            xcf = (fmt == FMT_444) ? 4 : 0;
            ycf = (fmt != FMT_420) ? 4 : 0;
            mx = (1 << bd) - 1;
            if (w.pred == PRED_PLANE) begin
                for (int c = 0; c < 2; c++) begin
                    hs = 0;
                    vs = 0;
                    for (int i = 0; i < 4 + xcf; i++)
                        hs += (i + 1) * (top_at(c, 4 + xcf + i) - top_at(c, 2 + xcf - i));
                    for (int i = 0; i < 4 + ycf; i++)
                        vs += (i + 1) * (left_at(c, 4 + ycf + i) - left_at(c, 2 + ycf - i));
                    pa[c] = 16 * (left_at(c, ht - 1) + top_at(c, wd - 1));
                    pb[c] = ((34 - 29 * ((fmt == FMT_444) ? 1 : 0)) * hs + 32) >>> 6;
                    pc[c] = ((34 - 29 * ((fmt != FMT_420) ? 1 : 0)) * vs + 32) >>> 6;
                end
            end
            for (int y = 0; y < ht; y++) begin
                for (int g = 0; g < wd / 4; g++) begin
                    r.row = 4'(y);
                    r.col_group = 2'(g);
                    for (int c = 0; c < 2; c++) begin
                        for (int k = 0; k < 4; k++) begin
                            case (w.pred)
                                PRED_DC: v = dc_val(c, g * 4 + k, y, ht, w.lt, w.lb, w.up, bd);
                                PRED_HOR: v = left_at(c, y);
                                PRED_VER: v = top_at(c, g * 4 + k);
                                default: begin
                                    v = (pa[c] + pb[c] * (g * 4 + k - 3 - xcf)
                                         + pc[c] * (y - 3 - ycf) + 16) >>> 5;
                                    if (v < 0) v = 0;
                                    if (v > mx) v = mx;
                                end
                            endcase
                            if (c == 0) r.cb[k] = SB'(v);
                            else r.cr[k] = SB'(v);
                        end
                    end
                    r.last = (y == ht - 1 && g == wd / 4 - 1);
                    r.status = 0;
                    want.push_back(r);
                end
            end
        endfunction

        function void field(string name, int e, int a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (want.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = want.pop_front();
            field("row", e.row, got.row);
            field("col_group", e.col_group, got.col_group);
            for (int k = 0; k < 4; k++) begin
                field($sformatf("cb%0d", k), e.cb[k], got.cb[k]);
                field($sformatf("cr%0d", k), e.cr[k], got.cr[k]);
            end
            field("last", e.last, got.last);
            field("status", e.status, got.status);
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n;
    logic i_valid, i_stall, i_cfg_valid;
    logic [1:0] i_mode, i_pred_mode;
    logic [3:0] i_index, i_cfg_data;
    logic [SB-1:0] i_cb_sample, i_cr_sample;
    logic i_left_top_avail, i_left_bottom_avail, i_up_avail, i_corner_avail;
    logic [0:0] i_cfg_index;
    logic o_stall, o_valid, o_last, o_status, o_cfg_ready;
    logic [3:0] o_row;
    logic [1:0] o_col_group;
    logic [SB-1:0] o_cb0, o_cb1, o_cb2, o_cb3, o_cr0, o_cr1, o_cr2, o_cr3;

    chroma_intra_predictor uut (.*);

    pred_scoreboard sb = new();
    int cycles = 0;
    bit calm_in, calm_out;

    initial forever #5 i_clk = ~i_clk;

    function int gap_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1;
        end else begin
            i_stall <= 0;
            stall_left <= gap_len(calm_out);
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.row = o_row;
            got.col_group = o_col_group;
            got.cb = '{o_cb0, o_cb1, o_cb2, o_cb3};
            got.cr = '{o_cr0, o_cr1, o_cr2, o_cr3};
            got.last = o_last;
            got.status = o_status;
            sb.check_result(got);
        end
    end

    task automatic send(t_word w);
        int g;
        i_valid <= 1;
        i_mode <= w.mode;
        i_index <= w.index;
        i_cb_sample <= w.cb;
        i_cr_sample <= w.cr;
        i_pred_mode <= w.pred;
        i_left_top_avail <= w.lt;
        i_left_bottom_avail <= w.lb;
        i_up_avail <= w.up;
        i_corner_avail <= w.cn;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(w);
        g = gap_len(calm_in);
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic load(t_mode m, int idx, int cb, int cr);
        t_word w;
        w = '{mode: m, index: 4'(idx), cb: SB'(cb), cr: SB'(cr), pred: PRED_DC,
              lt: 1'b0, lb: 1'b0, up: 1'b0, cn: 1'b0};
        send(w);
    endtask

    task automatic predict(t_pred p, bit lt, bit lb, bit up, bit cn);
        t_word w;
        w = '{mode: MODE_PREDICT, index: 4'($urandom), cb: SB'($urandom),
              cr: SB'($urandom), pred: p, lt: lt, lb: lb, up: up, cn: cn};
        send(w);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.want.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [3:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= r;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.set_reg(r, d);
        @(posedge i_clk);
    endtask

    task automatic random_word();
        t_word w;
        bit all;
        w.mode = t_mode'($urandom_range(0, 3));
        w.index = 4'($urandom);
        w.cb = SB'($urandom);
        w.cr = SB'($urandom);
        w.pred = t_pred'($urandom_range(0, 3));
        all = $urandom_range(0, 9) < 7;
        w.lt = all | 1'($urandom_range(0, 1));
        w.lb = all | 1'($urandom_range(0, 1));
        w.up = all | 1'($urandom_range(0, 1));
        w.cn = all | 1'($urandom_range(0, 1));
        if ($urandom_range(0, 2) != 0 && w.mode == MODE_PREDICT)
            w.mode = t_mode'($urandom_range(0, 2));
        send(w);
    endtask

    logic [3:0] depths[7] = '{4'd8, 4'd14, 4'd10, 4'd0, 4'd15, 4'd7, 4'd14};
    logic [3:0] fmts[7]   = '{4'd1, 4'd3, 4'd2, 4'd0, 4'd3, 4'd1, 4'd2};

    initial begin
        i_rst_n <= 0;
        i_valid <= 0;
        i_stall <= 0;
        i_cfg_valid <= 0;
        i_cfg_index <= 0;
        i_cfg_data <= 0;
        i_mode <= MODE_TOP;
        i_index <= 0;
        i_cb_sample <= 0;
        i_cr_sample <= 0;
        i_pred_mode <= PRED_DC;
        i_left_top_avail <= 0;
        i_left_bottom_avail <= 0;
        i_up_avail <= 0;
        i_corner_avail <= 0;
        calm_in = 1;
        calm_out = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (40) @(posedge i_clk);

        // every neighbour written before any predict reads it
        for (int i = 0; i < 16; i++) begin
            load(MODE_TOP, i, 16383, 0);
            load(MODE_LEFT, i, 0, 16383);
        end
        load(MODE_CORNER, 0, 16383, 0);

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_reg(REG_BIT_DEPTH, depths[ph]);
            write_reg(REG_CHROMA_FORMAT, fmts[ph]);
            calm_in = ph % 3 == 0;
            calm_out = ph % 3 == 1;
            if (ph == 0) begin
                predict(PRED_DC, 1, 1, 1, 1);
                predict(PRED_HOR, 1, 1, 0, 0);
                predict(PRED_VER, 0, 0, 1, 0);
                predict(PRED_PLANE, 1, 1, 1, 1);
                predict(PRED_DC, 0, 0, 0, 0);
                predict(PRED_DC, 1, 0, 0, 1);
                predict(PRED_DC, 0, 1, 1, 0);
                predict(PRED_DC, 0, 0, 1, 0);
                predict(PRED_HOR, 1, 0, 1, 1);
                predict(PRED_VER, 1, 1, 0, 1);
                predict(PRED_PLANE, 1, 1, 1, 0);
                predict(PRED_PLANE, 0, 1, 1, 1);
                load(MODE_CORNER, 0, 0, 16383);
                load(MODE_TOP, 15, 0, 16383);
                predict(PRED_PLANE, 1, 1, 1, 1);
            end
            repeat (19) random_word();
        end
        drain();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: filelist.f
src/cip_pkg.sv
src/cip_ram.sv
src/chroma_intra_predictor.sv
verif/testbench.sv
